// ----- rtl/cmcc_pkg.sv -----
// shared types and constants of the cascaded motor current controller
package cmcc_pkg;

	localparam int GAIN_W    = 16;
	localparam int MCAND_W   = 17;
	localparam int ACC_W     = 34;
	localparam int DIGIT_W   = 4;
	localparam int NUM_DIGITS = GAIN_W / DIGIT_W;
	localparam int CNT_W     = $clog2(NUM_DIGITS);
	localparam int CFG_IDX_W = 8;

	localparam int VEL_ERR_LIMIT = 1000;
	localparam int POS_ERR_LIMIT = 4000;
	localparam int INTEG_LIMIT   = 16667;
	localparam int CURRENT_LIMIT = 15000;

	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN     = 8'd3;

	localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 16'd3328;
	localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 16'd154;
	localparam logic [GAIN_W-1:0] RST_POS_GAIN   = 16'd38;

	typedef struct packed {
		logic start;
		logic keep;
	} smac_ctl_t;

endpackage

// ----- rtl/cmcc_smac.sv -----
// digit-serial signed by unsigned multiply-accumulate, four gain bits per cycle
module cmcc_smac import cmcc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  smac_ctl_t                 ctl,
	input  logic signed [MCAND_W-1:0] mcand,
	input  logic [GAIN_W-1:0]         mult,
	output logic                      busy,
	output logic signed [ACC_W-1:0]   acc
);

	logic signed [ACC_W-1:0] mcand_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] part;
	logic [GAIN_W-1:0]       mult_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;

	assign part = mcand_q * $signed({1'b0, mult_q[DIGIT_W-1:0]});
	assign busy = busy_q;
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_DIGITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q <= ACC_W'(mcand);
			mult_q  <= mult;
			if (!ctl.keep) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q   <= acc_q + part;
			mcand_q <= mcand_q <<< DIGIT_W;
			mult_q  <= mult_q >> DIGIT_W;
		end
	end

endmodule

// ----- rtl/cascaded_motor_current_controller.sv -----
// top level: cascaded position p and velocity pi current controller for several motors
//
//  channel | signals                                             | direction
//  in      | in_valid in_ready motor_index target_* measured_*  | beat in
//  out     | out_valid out_ready drive_current integrator_saturated | beat out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data              | register write
//
// one tick runs through prep, pmul and tvel (position mode only), integ, mul1, mul2, out;
// the four-bit serial multiplier makes two or three passes of one 16-bit gain product each
// a finished result waits in the output register; the next beat is taken meanwhile
// reset clears the gains to defaults, the mode to velocity and every integrator to zero
// cfg_ready is always high
module cascaded_motor_current_controller import cmcc_pkg::*; #(
	parameter int NUM_MOTORS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             motor_index,
	input  logic signed [15:0]     target_velocity,
	input  logic signed [31:0]     target_position,
	input  logic signed [15:0]     measured_velocity,
	input  logic signed [31:0]     measured_position,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [14:0]     drive_current,
	output logic                   integrator_saturated,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [GAIN_W-1:0]      cfg_data
);

	localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int QW    = ACC_W - 8;
	localparam logic [4:0] NUM_V = 5'(NUM_MOTORS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_PMUL  = 3'd2;
	localparam logic [2:0] ST_TVEL  = 3'd3;
	localparam logic [2:0] ST_INTEG = 3'd4;
	localparam logic [2:0] ST_MUL1  = 3'd5;
	localparam logic [2:0] ST_MUL2  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	function automatic logic signed [QW-1:0] trunc_div256(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] b;
		b = a + (a[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
		return b[ACC_W-1:8];
	endfunction

	logic [2:0]                state_q;
	logic                      mode_q;
	logic [GAIN_W-1:0]         prop_gain_q;
	logic [GAIN_W-1:0]         integ_gain_q;
	logic [GAIN_W-1:0]         pos_gain_q;

	logic [IDX_W-1:0]          idx_q;
	logic signed [15:0]        tv_q;
	logic signed [31:0]        tp_q;
	logic signed [15:0]        mv_q;
	logic signed [31:0]        mp_q;
	logic signed [16:0]        verr_q;
	logic signed [15:0]        sum_q;
	logic                      sat_q;
	logic signed [15:0]        integ_q [NUM_MOTORS];

	logic                      out_valid_q;
	logic signed [14:0]        dc_q;
	logic                      osat_q;

	logic [4:0]                midx_c;
	logic signed [32:0]        pdiff_c;
	logic signed [12:0]        perr_c;
	logic signed [16:0]        vdiff_c;
	logic signed [16:0]        vclamp_c;
	logic signed [QW-1:0]      tq_c;
	logic signed [15:0]        tvel_c;
	logic signed [16:0]        tverr_c;
	logic signed [17:0]        sum_c;
	logic signed [15:0]        sumc_c;
	logic                      sat_c;
	logic signed [14:0]        cur_c;
	logic                      load_out;

	smac_ctl_t                 ctl_c;
	logic signed [MCAND_W-1:0] mcand_c;
	logic [GAIN_W-1:0]         mult_c;
	logic                      busy;
	logic signed [ACC_W-1:0]   acc;

	assign in_ready             = (state_q == ST_IDLE);
	assign cfg_ready            = 1'b1;
	assign out_valid            = out_valid_q;
	assign drive_current        = dc_q;
	assign integrator_saturated = osat_q;
	assign load_out             = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// motor index folded into range
	always_comb begin
		midx_c = 5'(motor_index);
		for (int i = 0; i < 3; i++) begin
			if (midx_c >= NUM_V) begin
				midx_c = midx_c - NUM_V;
			end
		end
	end

	assign pdiff_c = 33'(tp_q) - 33'(mp_q);
	always_comb begin
		if (pdiff_c > 33'(POS_ERR_LIMIT)) begin
			perr_c = 13'(POS_ERR_LIMIT);
		end else if (pdiff_c < 33'(-POS_ERR_LIMIT)) begin
			perr_c = 13'(-POS_ERR_LIMIT);
		end else begin
			perr_c = pdiff_c[12:0];
		end
	end

	assign vdiff_c = 17'(tv_q) - 17'(mv_q);
	always_comb begin
		if (vdiff_c > 17'(VEL_ERR_LIMIT)) begin
			vclamp_c = 17'(VEL_ERR_LIMIT);
		end else if (vdiff_c < 17'(-VEL_ERR_LIMIT)) begin
			vclamp_c = 17'(-VEL_ERR_LIMIT);
		end else begin
			vclamp_c = vdiff_c;
		end
	end

	assign tq_c = trunc_div256(acc);
	always_comb begin
		if (tq_c > QW'(32767)) begin
			tvel_c = 16'sh7fff;
		end else if (tq_c < QW'(-32768)) begin
			tvel_c = 16'sh8000;
		end else begin
			tvel_c = tq_c[15:0];
		end
	end
	assign tverr_c = 17'(tvel_c) - 17'(mv_q);

	assign sum_c = 18'(integ_q[idx_q]) + 18'(verr_q);
	always_comb begin
		sat_c = 1'b0;
		if (sum_c > 18'(INTEG_LIMIT)) begin
			sumc_c = 16'(INTEG_LIMIT);
			sat_c  = 1'b1;
		end else if (sum_c < 18'(-INTEG_LIMIT)) begin
			sumc_c = 16'(-INTEG_LIMIT);
			sat_c  = 1'b1;
		end else begin
			sumc_c = sum_c[15:0];
		end
	end

	always_comb begin
		if (tq_c > QW'(CURRENT_LIMIT)) begin
			cur_c = 15'(CURRENT_LIMIT);
		end else if (tq_c < QW'(-CURRENT_LIMIT)) begin
			cur_c = 15'(-CURRENT_LIMIT);
		end else begin
			cur_c = tq_c[14:0];
		end
	end

	always_comb begin
		ctl_c.start = 1'b0;
		ctl_c.keep  = 1'b0;
		case (state_q)
			ST_PREP: begin
				ctl_c.start = mode_q;
				mcand_c     = 17'(perr_c);
				mult_c      = pos_gain_q;
			end
			ST_INTEG: begin
				ctl_c.start = 1'b1;
				mcand_c     = verr_q;
				mult_c      = prop_gain_q;
			end
			ST_MUL1: begin
				ctl_c.start = !busy;
				ctl_c.keep  = 1'b1;
				mcand_c     = 17'(sum_q);
				mult_c      = integ_gain_q;
			end
			default: begin
				mcand_c = 17'(sum_q);
				mult_c  = integ_gain_q;
			end
		endcase
	end

	cmcc_smac u_smac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_c),
		.mcand  (mcand_c),
		.mult   (mult_c),
		.busy   (busy),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			prop_gain_q  <= RST_PROP_GAIN;
			integ_gain_q <= RST_INTEG_GAIN;
			pos_gain_q   <= RST_POS_GAIN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CONTROL_MODE: mode_q       <= cfg_data[0];
				REG_PROP_GAIN:    prop_gain_q  <= cfg_data;
				REG_INTEG_GAIN:   integ_gain_q <= cfg_data;
				REG_POS_GAIN:     pos_gain_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_PREP;
				ST_PREP:  state_q <= mode_q ? ST_PMUL : ST_INTEG;
				ST_PMUL:  if (!busy) state_q <= ST_TVEL;
				ST_TVEL:  state_q <= ST_INTEG;
				ST_INTEG: state_q <= ST_MUL1;
				ST_MUL1:  if (!busy) state_q <= ST_MUL2;
				ST_MUL2:  if (!busy) state_q <= ST_OUT;
				ST_OUT:   if (load_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				integ_q[i] <= '0;
			end
		end else if (state_q == ST_INTEG) begin
			integ_q[idx_q] <= sumc_c;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			idx_q <= midx_c[IDX_W-1:0];
			tv_q  <= target_velocity;
			tp_q  <= target_position;
			mv_q  <= measured_velocity;
			mp_q  <= measured_position;
		end
		if (state_q == ST_PREP && !mode_q) begin
			verr_q <= vclamp_c;
		end
		if (state_q == ST_TVEL) begin
			verr_q <= tverr_c;
		end
		if (state_q == ST_INTEG) begin
			sum_q <= sumc_c;
			sat_q <= sat_c;
		end
		if (load_out) begin
			dc_q   <= cur_c;
			osat_q <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/cmcc_checker.sv -----
// port-level checks of the controller and their binding to the top level
module cmcc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] drive_current,
	input logic               integrator_saturated
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_current)
			&& $stable(integrator_saturated))
		else $error("result beat changed while stalled");

	// current stays inside the clamp
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_current <= 15'sd15000) && (drive_current >= -15'sd15000))
		else $error("drive current outside limit");

	// one tick at a time
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while tick in progress");

	// no result appears in the cycle right after an input beat
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared without computation");

endmodule

bind cascaded_motor_current_controller cmcc_checker u_cmcc_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.in_valid             (in_valid),
	.in_ready             (in_ready),
	.out_valid            (out_valid),
	.out_ready            (out_ready),
	.drive_current        (drive_current),
	.integrator_saturated (integrator_saturated)
);

// ----- verif/cascaded_motor_current_controller_test.sv -----
// testbench for the cascaded motor current controller: directed and random ticks against a predictor
module cascaded_motor_current_controller_test import cmcc_pkg::*; ();

	localparam int NUM_MOTORS = 4;
	localparam int N_DIRECTED = 18;
	localparam int PHASES = 10;
	localparam int PHASE_TICKS = 160;
	localparam int PRESSURE_PHASE = 3;
	localparam int BURST_TICKS = 48;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE = 24;
	localparam int TAIL = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hff;

	typedef enum logic {
		MODE_VELOCITY = 1'b0,
		MODE_POSITION = 1'b1
	} loop_mode_e;

	typedef struct packed {
		logic [1:0]         motor;
		logic signed [15:0] tv;
		logic signed [31:0] tp;
		logic signed [15:0] mv;
		logic signed [31:0] mp;
	} tick_t;

	typedef struct packed {
		logic signed [14:0] current;
		logic               saturated;
	} drive_t;

	typedef struct packed {
		loop_mode_e mode;
		tick_t      tick;
		logic       pinned;
		drive_t     drive;
	} tick_row_t;

	localparam tick_row_t DIRECTED [N_DIRECTED] = '{
		'{MODE_VELOCITY, '{2'd0, 16'sd0, 32'sh7fffffff, 16'sd0, 32'sh80000000}, 1'b1,
			'{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd1, 16'sh7fff, 32'sd0, 16'sh8000, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd2, 16'sh8000, 32'sh80000000, 16'sh7fff, 32'sh7fffffff}, 1'b0,
			'{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd3, 16'sd500, 32'sd0, 16'sd499, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd0, -16'sd1, 32'sd0, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd1, 16'sd1000, 32'sd0, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd2, 16'sd1001, 32'sd0, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd3, -16'sd1001, 32'sd0, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_POSITION, '{2'd0, 16'sh7fff, 32'sh7fffffff, 16'sh8000, 32'sh80000000}, 1'b1,
			'{15'sd15000, 1'b1}},
		'{MODE_POSITION, '{2'd1, 16'sh8000, 32'sh80000000, 16'sh7fff, 32'sh7fffffff}, 1'b1,
			'{-15'sd15000, 1'b1}},
		'{MODE_POSITION, '{2'd2, 16'sd0, 32'sd4000, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_POSITION, '{2'd2, 16'sd0, 32'sd4001, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_POSITION, '{2'd3, 16'sd0, -32'sd4000, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_POSITION, '{2'd3, 16'sd0, -32'sd4001, 16'sd0, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_POSITION, '{2'd0, 16'sd0, 32'sd0, 16'sh7fff, 32'sd0}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_POSITION, '{2'd1, 16'sd0, 32'sd100, 16'sd0, 32'sd99}, 1'b0, '{15'sd0, 1'b0}},
		'{MODE_POSITION, '{2'd2, 16'sd0, 32'sh7fffffff, 16'sd0, 32'sh7ffff000}, 1'b0,
			'{15'sd0, 1'b0}},
		'{MODE_VELOCITY, '{2'd3, 16'sd5, 32'sd0, 16'sd5, 32'sd0}, 1'b0, '{15'sd0, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] motor_index;
	logic signed [15:0] target_velocity;
	logic signed [31:0] target_position;
	logic signed [15:0] measured_velocity;
	logic signed [31:0] measured_position;
	logic out_valid;
	logic out_ready;
	logic signed [14:0] drive_current;
	logic integrator_saturated;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0] cfg_data;

	loop_mode_e mode_q = MODE_VELOCITY;
	logic [15:0] kp_q = RST_PROP_GAIN;
	logic [15:0] ki_q = RST_INTEG_GAIN;
	logic [15:0] kpos_q = RST_POS_GAIN;
	logic signed [15:0] integ_q [NUM_MOTORS] = '{default: 16'sd0};

	drive_t drive_pending [$];
	logic pin_active = 1'b0;
	drive_t pin_drive;
	logic steady = 1'b0;
	logic hold_long = 1'b0;
	int errors = 0;

	cascaded_motor_current_controller #(
		.NUM_MOTORS(NUM_MOTORS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.motor_index(motor_index),
		.target_velocity(target_velocity),
		.target_position(target_position),
		.measured_velocity(measured_velocity),
		.measured_position(measured_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_current(drive_current),
		.integrator_saturated(integrator_saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint velocity_target(input longint perr);
		return clamp((longint'(kpos_q) * perr) / 256, -32768, 32767);
	endfunction

	function automatic longint position_error(input tick_t t);
		return clamp(longint'($signed(t.tp)) - longint'($signed(t.mp)),
			-POS_ERR_LIMIT, POS_ERR_LIMIT);
	endfunction

	// advances the motor's integrator and returns the commanded current and saturation flag
	function automatic drive_t predict_drive(input tick_t t);
		longint verr;
		longint sum;
		longint acc;
		drive_t d;
		int slot;
		slot = int'(t.motor) % NUM_MOTORS;
		if (mode_q == MODE_POSITION) begin
			verr = velocity_target(position_error(t)) - longint'($signed(t.mv));
		end else begin
			verr = clamp(longint'($signed(t.tv)) - longint'($signed(t.mv)),
				-VEL_ERR_LIMIT, VEL_ERR_LIMIT);
		end
		sum = longint'(integ_q[slot]) + verr;
		d.saturated = (sum > INTEG_LIMIT) || (sum < -INTEG_LIMIT);
		sum = clamp(sum, -INTEG_LIMIT, INTEG_LIMIT);
		integ_q[slot] = 16'(sum);
		acc = longint'(kp_q) * verr + longint'(ki_q) * sum;
		d.current = 15'(clamp(acc / 256, -CURRENT_LIMIT, CURRENT_LIMIT));
		return d;
	endfunction

	function automatic logic [15:0] random_gain();
		return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
	endfunction

	// mostly measurements near the set point, some noise and rail values
	function automatic tick_t random_tick();
		tick_t t;
		int dv;
		t.motor = 2'($urandom_range(0, 3));
		t.tv = 16'($urandom);
		t.tp = $urandom;
		t.mv = 16'($urandom);
		t.mp = $urandom;
		dv = $urandom_range(0, 2400);
		dv = dv - 1200;
		case ($urandom_range(0, 9))
			0, 1: begin
			end
			2: begin
				t.tv = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
				t.mv = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
				t.tp = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
				t.mp = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			end
			default: begin
				t.mp = t.tp + 32'($urandom_range(0, 10000)) - 32'd5000;
				if (mode_q == MODE_POSITION) begin
					t.mv = 16'(velocity_target(position_error(t)) + dv);
				end else begin
					t.tv = 16'(int'($urandom_range(0, 8000)) - 4000);
					t.mv = 16'(int'($signed(t.tv)) + dv);
				end
			end
		endcase
		return t;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch: %s got %0d expected %0d", what, got, want);
	endtask

	always @(posedge clk) begin : drive_monitor
		drive_t want;
		drive_t predicted;
		tick_t t;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (drive_pending.size() == 0) begin
					report_mismatch("drive beat with nothing pending", drive_current, 0);
				end else begin
					want = drive_pending.pop_front();
					if (drive_current !== want.current)
						report_mismatch("drive_current", drive_current, $signed(want.current));
					if (integrator_saturated !== want.saturated)
						report_mismatch("integrator_saturated", integrator_saturated,
							want.saturated);
				end
			end
			if (in_valid && in_ready) begin
				t = '{motor_index, target_velocity, target_position, measured_velocity,
					measured_position};
				predicted = predict_drive(t);
				drive_pending.push_back(pin_active ? pin_drive : predicted);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CONTROL_MODE: mode_q = loop_mode_e'(cfg_data[0]);
					REG_PROP_GAIN:    kp_q = cfg_data;
					REG_INTEG_GAIN:   ki_q = cfg_data;
					REG_POS_GAIN:     kpos_q = cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	task automatic send_tick(input tick_t t);
		in_valid <= 1'b1;
		motor_index <= t.motor;
		target_velocity <= t.tv;
		target_position <= t.tp;
		measured_velocity <= t.mv;
		measured_position <= t.mp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		if (!steady && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_config(input loop_mode_e mode, input logic [15:0] kp,
		input logic [15:0] ki, input logic [15:0] kpos);
		write_reg(REG_CONTROL_MODE, {15'($urandom), logic'(mode)});
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_POS_GAIN, kpos);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (drive_pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin : drive_sink
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_long = 1'b0;
				out_ready <= 1'b1;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : tick_source
		loop_mode_e cur_mode;
		int r;
		int phase;
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		motor_index = '0;
		target_velocity = '0;
		target_position = '0;
		measured_velocity = '0;
		measured_position = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_UNUSED, 16'hffff);
		cfg_valid <= 1'b0;
		cur_mode = MODE_VELOCITY;
		for (r = 0; r < N_DIRECTED; r++) begin
			if (DIRECTED[r].mode != cur_mode) begin
				drain_results();
				write_reg(REG_CONTROL_MODE, {15'd0, logic'(DIRECTED[r].mode)});
				cfg_valid <= 1'b0;
				cur_mode = DIRECTED[r].mode;
			end
			pin_active = DIRECTED[r].pinned;
			pin_drive = DIRECTED[r].drive;
			send_tick(DIRECTED[r].tick);
			pause_sender();
		end
		pin_active = 1'b0;

		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: apply_config(MODE_VELOCITY, RST_PROP_GAIN, RST_INTEG_GAIN, RST_POS_GAIN);
				1: apply_config(MODE_POSITION, RST_PROP_GAIN, RST_INTEG_GAIN, RST_POS_GAIN);
				2: apply_config(MODE_VELOCITY, 16'hffff, 16'hffff, 16'hffff);
				3: apply_config(MODE_POSITION, 16'hffff, 16'hffff, 16'hffff);
				4: apply_config(MODE_VELOCITY, 16'h0000, 16'h0000, 16'h0000);
				5: apply_config(MODE_POSITION, 16'h0000, 16'h0000, 16'h0000);
				default: apply_config(loop_mode_e'(phase % 2), random_gain(), random_gain(),
					random_gain());
			endcase
			if (phase == PHASES - 1)
				steady = 1'b1;
			if (phase == PRESSURE_PHASE)
				hold_long = 1'b1;
			for (i = 0; i < PHASE_TICKS; i++) begin
				send_tick(random_tick());
				if (!(phase == PRESSURE_PHASE && i < BURST_TICKS))
					pause_sender();
			end
		end

		in_valid <= 1'b0;
		while (drive_pending.size() != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);
		if (errors == 0)
			$display("cascaded_motor_current_controller_test passed");
		else
			$display("cascaded_motor_current_controller_test failed");
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("cascaded_motor_current_controller_test failed");
		$finish;
	end

endmodule
